// ===== src/tnls_pkg.sv =====
// Package for the trajectory nearest and lookahead point search.
// Holds field widths, register indexes and status codes; no dependencies.
package tnls_pkg;

  // Defaults and fixed constants
  localparam int MAX_POINTS_DEF = 256;
  localparam int MIN_POINTS     = 3;

  // Field widths
  localparam int COORD_W  = 24;              // Q14.10 coordinates
  localparam int DIFF_W   = COORD_W + 1;     // exact difference
  localparam int SQ_W     = 2 * COORD_W + 1; // one squared difference, below 2^49
  localparam int D2_W     = SQ_W + 1;        // sum of two squares
  localparam int MIN_W    = 51;              // running minimum, reset to all ones
  localparam int L2_W     = 2 * COORD_W;     // squared lookahead distance
  localparam int IDX_OUT_W = 8;
  localparam int STATUS_W = 2;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_VEHICLE_X = 2'd0;
  localparam reg_idx_t REG_VEHICLE_Y = 2'd1;
  localparam reg_idx_t REG_LOOKAHEAD = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_TOO_FEW  = 2'd1;
  localparam status_t STATUS_OVERFLOW = 2'd2;

endpackage

// ===== src/trajectory_nearest_and_lookahead_search.sv =====
// Top level of the trajectory nearest and lookahead point search.
// Depends on tnls_pkg for widths, register indexes and status codes.
//
// Use: program vehicle_x, vehicle_y and lookahead_distance over the APB port
// (byte addresses 0, 4, 8) while the block is idle, then stream the trajectory
// one point per item on the in_ channel, the final point with in_last_point set.
// Each marked last point yields one result item on the out_ channel with the
// nearest index, the lookahead index and a status (ok, too few, overflow);
// other points yield none. Points past MAX_POINTS are dropped and flagged.
// Throughput: one point per cycle while in_stall is low. The path is an input
// register, a register of the two squared differences, then the add and
// compares against the running minimum, which update the trajectory state and
// the result register, from which the result of a last point is shown.
// When the receiver stalls, the result holds in the output register; the block
// keeps taking points and only stalls its input once a second result reaches
// the compare stage while the first still waits.
// Reset (rst_n low at a clock edge) clears the settings to zero, the pipeline
// to empty and the trajectory state to its start values; no clearing pass.
module trajectory_nearest_and_lookahead_search #(
  parameter int MAX_POINTS = tnls_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // point channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tnls_pkg::COORD_W-1:0]    in_point_x,
  input  logic signed [tnls_pkg::COORD_W-1:0]    in_point_y,
  input  logic                                   in_last_point,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [tnls_pkg::IDX_OUT_W-1:0]         out_nearest_index,
  output logic [tnls_pkg::IDX_OUT_W-1:0]         out_lookahead_index,
  output logic [tnls_pkg::STATUS_W-1:0]          out_status,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tnls_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [tnls_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [tnls_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CW    = tnls_pkg::COORD_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]           vehicle_x_r;
  logic signed [CW-1:0]           vehicle_y_r;
  logic [CW-1:0]                  lookahead_r;
  logic [tnls_pkg::L2_W-1:0]      l2_r;
  logic                           cfg_wr;
  tnls_pkg::reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  // Write the addressed register; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vehicle_x_r <= '0;
      vehicle_y_r <= '0;
      lookahead_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tnls_pkg::REG_VEHICLE_X: vehicle_x_r <= pwdata[CW-1:0];
        tnls_pkg::REG_VEHICLE_Y: vehicle_y_r <= pwdata[CW-1:0];
        tnls_pkg::REG_LOOKAHEAD: lookahead_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Square the lookahead distance in a register, off the point path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_r <= '0;
    end else begin
      l2_r <= lookahead_r * lookahead_r;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      tnls_pkg::REG_VEHICLE_X: prdata = {{(tnls_pkg::APB_DATA_W-CW){1'b0}}, vehicle_x_r};
      tnls_pkg::REG_VEHICLE_Y: prdata = {{(tnls_pkg::APB_DATA_W-CW){1'b0}}, vehicle_y_r};
      tnls_pkg::REG_LOOKAHEAD: prdata = {{(tnls_pkg::APB_DATA_W-CW){1'b0}}, lookahead_r};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: stall only when a result meets a full, stalled output
  // ---------------------------------------------------------------------------
  logic in_valid_r;
  logic in_last_r;
  logic signed [CW-1:0] in_x_r;
  logic signed [CW-1:0] in_y_r;
  logic sq_valid_r;
  logic sq_last_r;
  logic [tnls_pkg::SQ_W-1:0] sq_x_r;
  logic [tnls_pkg::SQ_W-1:0] sq_y_r;
  logic out_free;
  logic adv;

  assign out_free = !out_valid || !out_stall;
  assign adv      = !(sq_valid_r && sq_last_r && !out_free);
  assign in_stall = !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_x_r    <= in_point_x;
      in_y_r    <= in_point_y;
      in_last_r <= in_last_point;
    end
  end

  // Difference and square of each axis
  logic signed [tnls_pkg::DIFF_W-1:0] dx;
  logic signed [tnls_pkg::DIFF_W-1:0] dy;
  logic [tnls_pkg::DIFF_W-1:0]        ax;
  logic [tnls_pkg::DIFF_W-1:0]        ay;
  logic [2*tnls_pkg::DIFF_W-1:0]      ax2;
  logic [2*tnls_pkg::DIFF_W-1:0]      ay2;

  assign dx  = {in_x_r[CW-1], in_x_r} - {vehicle_x_r[CW-1], vehicle_x_r};
  assign dy  = {in_y_r[CW-1], in_y_r} - {vehicle_y_r[CW-1], vehicle_y_r};
  assign ax  = dx[tnls_pkg::DIFF_W-1] ? tnls_pkg::DIFF_W'(-dx) : tnls_pkg::DIFF_W'(dx);
  assign ay  = dy[tnls_pkg::DIFF_W-1] ? tnls_pkg::DIFF_W'(-dy) : tnls_pkg::DIFF_W'(dy);
  assign ax2 = ax * ax;
  assign ay2 = ay * ay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (adv) begin
      sq_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r    <= ax2[tnls_pkg::SQ_W-1:0];
      sq_y_r    <= ay2[tnls_pkg::SQ_W-1:0];
      sq_last_r <= in_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Running minimum and lookahead tracking
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]             count_r,  count_nxt;
  logic [tnls_pkg::MIN_W-1:0]   min_r,    min_nxt;
  logic [IDX_W-1:0]             best_r,   best_nxt;
  logic [IDX_W-1:0]             ahead_r,  ahead_nxt;
  logic                         found_r,  found_nxt;
  logic                         ovf_r,    ovf_nxt;

  logic [tnls_pkg::D2_W-1:0]    d2;
  logic                         closer;
  logic                         reach;
  logic                         full;
  logic [IDX_W-1:0]             idx;
  logic                         fire;
  logic                         few;
  logic [CNT_W-1:0]             last_idx;

  logic                         res_load;
  logic [tnls_pkg::IDX_OUT_W-1:0] res_closest;
  logic [tnls_pkg::IDX_OUT_W-1:0] res_ahead;
  tnls_pkg::status_t            res_status;

  assign d2     = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign closer = {{(tnls_pkg::MIN_W-tnls_pkg::D2_W){1'b0}}, d2} < min_r;
  assign reach  = d2 >= {{(tnls_pkg::D2_W-tnls_pkg::L2_W){1'b0}}, l2_r};
  assign full   = count_r == CNT_W'(MAX_POINTS);
  assign idx    = count_r[IDX_W-1:0];
  assign fire   = sq_valid_r && adv;

  // Fold one point into the trajectory state
  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    best_nxt  = best_r;
    ahead_nxt = ahead_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    if (full) begin
      ovf_nxt = 1'b1;
    end else begin
      if (closer) begin
        min_nxt   = {{(tnls_pkg::MIN_W-tnls_pkg::D2_W){1'b0}}, d2};
        best_nxt  = idx;
        found_nxt = reach;
        ahead_nxt = reach ? idx : '0;
      end else if (!found_r && reach) begin
        found_nxt = 1'b1;
        ahead_nxt = idx;
      end
      count_nxt = count_r + 1'b1;
    end
  end

  // Form the result from the state after the last point
  assign few      = count_nxt < CNT_W'(tnls_pkg::MIN_POINTS);
  assign last_idx = count_nxt - 1'b1;
  assign res_load = fire && sq_last_r;

  always_comb begin
    if (few) begin
      res_closest = '0;
      res_ahead   = '0;
      res_status  = tnls_pkg::STATUS_TOO_FEW;
    end else begin
      res_closest = tnls_pkg::IDX_OUT_W'(best_nxt);
      res_ahead   = found_nxt ? tnls_pkg::IDX_OUT_W'(ahead_nxt)
                              : tnls_pkg::IDX_OUT_W'(last_idx);
      res_status  = ovf_nxt ? tnls_pkg::STATUS_OVERFLOW : tnls_pkg::STATUS_OK;
    end
  end

  // Update the state; clear it after the last point
  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      count_r <= '0;
      min_r   <= '1;
      best_r  <= '0;
      ahead_r <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      best_r  <= best_nxt;
      ahead_r <= ahead_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled
  // ---------------------------------------------------------------------------
  logic                           out_valid_r;
  logic [tnls_pkg::IDX_OUT_W-1:0] out_closest_r;
  logic [tnls_pkg::IDX_OUT_W-1:0] out_ahead_r;
  tnls_pkg::status_t              out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_closest_r <= res_closest;
      out_ahead_r   <= res_ahead;
      out_status_r  <= res_status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_nearest_index   = out_closest_r;
  assign out_lookahead_index = out_ahead_r;
  assign out_status          = out_status_r;

endmodule

// ===== src/tnls_checker.sv =====
// Port-level checks for the trajectory nearest and lookahead point search.
// Depends on tnls_pkg; bound to the top level at the end of this file.
module tnls_checker #(
  parameter int MAX_POINTS = tnls_pkg::MAX_POINTS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [tnls_pkg::IDX_OUT_W-1:0]      out_nearest_index,
  input logic [tnls_pkg::IDX_OUT_W-1:0]      out_lookahead_index,
  input logic [tnls_pkg::STATUS_W-1:0]       out_status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_nearest_index)
      && $stable(out_lookahead_index) && $stable(out_status))
    else $error("result changed while stalled");

  // Status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == tnls_pkg::STATUS_OK)
      || (out_status == tnls_pkg::STATUS_TOO_FEW)
      || (out_status == tnls_pkg::STATUS_OVERFLOW))
    else $error("undefined status code");

  // A short trajectory reports zero indices
  a_too_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tnls_pkg::STATUS_TOO_FEW
      |-> out_nearest_index == '0 && out_lookahead_index == '0)
    else $error("too-few result with nonzero index");

  // The lookahead point never lies before the nearest point (when MAX_POINTS <= 256)
  a_ahead_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && MAX_POINTS <= 256 |-> out_lookahead_index >= out_nearest_index)
    else $error("lookahead index before nearest index");

endmodule

bind trajectory_nearest_and_lookahead_search tnls_checker #(
  .MAX_POINTS(MAX_POINTS)
) u_tnls_checker (.*);
